@@ hw/rtl/dcr_pkg.sv @@
// Shared types and constants for the disk controller register block.
package dcr_pkg;

    // Default sizes of the attached drive set.
    localparam int UNITS_DEF             = 4;
    localparam int SECTORS_PER_TRACK_DEF = 40;
    localparam int CYLINDERS_DEF         = 512;

    // Fixed field widths, and the status FIFO depth and pointer width.
    localparam int CYL_W      = 9;
    localparam int SEC_W      = 6;
    localparam int UNIT_W     = 2;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;

    // Bus operation codes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register indexes.
    localparam logic [2:0] REG_CSR = 3'd0;
    localparam logic [2:0] REG_BA  = 3'd1;
    localparam logic [2:0] REG_DA  = 3'd2;
    localparam logic [2:0] REG_MP  = 3'd3;
    localparam logic [2:0] REG_AE  = 3'd4;

    // Command function codes in CSR bits 3..1.
    localparam logic [2:0] FN_GET_STATUS  = 3'd2;
    localparam logic [2:0] FN_SEEK        = 3'd3;
    localparam logic [2:0] FN_READ_HEADER = 3'd4;

    // CSR bit masks.
    localparam logic [15:0] CSR_DRDY  = 16'h0001;
    localparam logic [15:0] CSR_CRDY  = 16'h0080;
    localparam logic [15:0] CSR_WMASK = 16'h03FE;
    localparam logic [15:0] CSR_ERRS  = 16'hBC00;
    localparam logic [15:0] CSR_ERR   = 16'h8000;
    localparam logic [15:0] ERR_OPI   = 16'h0400;
    localparam logic [15:0] CSR_RESET = 16'h0081;

    // Get-status base word and header CRC polynomial.
    localparam logic [15:0] STAT_BASE = 16'h009D;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    // One bus access.
    typedef struct packed {
        logic        operation;
        logic [2:0]  reg_index;
        logic [15:0] write_value;
    } dcr_in_t;

    // One bus access result.
    typedef struct packed {
        logic [15:0] read_value;
        logic        interrupt_pulse;
    } dcr_out_t;

endpackage

@@ hw/rtl/dcr_crc16.sv @@
// Header CRC: reflected CRC-16 of one address word followed by a zero word.
module dcr_crc16 import dcr_pkg::*;
(
    input  logic [15:0] data,
    output logic [15:0] crc
);

    // Bit-serial reference, evaluated only on constants to build the columns.
    function automatic logic [15:0] crc_serial(input logic [15:0] w);
        logic [15:0] acc;
        logic [31:0] bits;
        acc  = 16'h0000;
        bits = {16'h0000, w};
        for (int k = 0; k < 32; k++)
        begin
            if (acc[0] ^ bits[k])
            begin
                acc = (acc >> 1) ^ CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    logic [15:0] col [16];

    // The CRC with zero preset is linear, so each data bit adds one column.
    for (genvar i = 0; i < 16; i++)
    begin : g_col
        assign col[i] = crc_serial(16'(1) << i);
    end

    // Sum the columns of the set data bits.
    always_comb
    begin
        crc = 16'h0000;
        for (int i = 0; i < 16; i++)
        begin
            if (data[i])
            begin
                crc = crc ^ col[i];
            end
        end
    end

endmodule

@@ hw/rtl/dcr_regs.sv @@
// Register file, per-unit position state, status FIFO and command execution.
module dcr_regs import dcr_pkg::*;
#(
    parameter int UNITS             = UNITS_DEF,
    parameter int SECTORS_PER_TRACK = SECTORS_PER_TRACK_DEF,
    parameter int CYLINDERS         = CYLINDERS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     exec,
    input  dcr_in_t  item,
    output dcr_out_t result
);

    localparam logic signed [CYL_W+1:0] CYL_MAX = (CYL_W + 2)'(CYLINDERS - 1);
    localparam logic [SEC_W:0]          SPT     = (SEC_W + 1)'(SECTORS_PER_TRACK);

    logic [15:0]           csr_reg, csr_next;
    logic [15:0]           ba_reg, ba_next;
    logic [15:0]           da_reg, da_next;
    logic [5:0]            ae_reg, ae_next;
    logic [FIFO_PTR_W-1:0] ptr_reg, ptr_next;
    logic [CYL_W-1:0]      cyl_reg  [UNITS];
    logic [CYL_W-1:0]      cyl_next [UNITS];
    logic                  head_reg  [UNITS];
    logic                  head_next [UNITS];
    logic [SEC_W-1:0]      sec_reg  [UNITS];
    logic [SEC_W-1:0]      sec_next [UNITS];
    logic [15:0]           fifo_reg [FIFO_DEPTH];

    logic [15:0]           csr_wr;
    logic [15:0]           csr_work;
    logic [2:0]            fn;
    logic [UNIT_W-1:0]     unit;
    logic                  present;
    logic [CYL_W-1:0]      sel_cyl;
    logic                  sel_head;
    logic [SEC_W-1:0]      sel_sec;
    logic [15:0]           hdr_word;
    logic [15:0]           hdr_crc;
    logic signed [CYL_W+1:0] seek_sum;
    logic [CYL_W-1:0]      seek_cyl;
    logic [SEC_W-1:0]      sec_base;
    logic [SEC_W:0]        sec_inc;
    logic [SEC_W-1:0]      sec_step;
    logic                  fifo_fill;
    logic [15:0]           fifo_w0;
    logic [15:0]           fifo_w2;
    logic [15:0]           rv;
    logic                  irq;

    // CSR value after a CSR write; the command comes from this value.
    assign csr_wr  = (csr_reg & ~CSR_WMASK) | (item.write_value & CSR_WMASK);
    assign fn      = csr_wr[3:1];
    assign unit    = csr_wr[9:8];
    assign present = 32'(unit) < UNITS;

    // Select the addressed unit's position.
    always_comb
    begin
        sel_cyl  = '0;
        sel_head = 1'b0;
        sel_sec  = '0;
        for (int u = 0; u < UNITS; u++)
        begin
            if (32'(unit) == u)
            begin
                sel_cyl  = cyl_reg[u];
                sel_head = head_reg[u];
                sel_sec  = sec_reg[u];
            end
        end
    end

    // Header word and its CRC.
    assign hdr_word = {sel_cyl, sel_head, sel_sec};

    dcr_crc16 u_crc (
        .data (hdr_word),
        .crc  (hdr_crc)
    );

    // Seek target, clamped to the cylinder range.
    always_comb
    begin
        if (da_reg[2])
        begin
            seek_sum = $signed({2'b00, sel_cyl}) + $signed({2'b00, da_reg[15:7]});
        end
        else
        begin
            seek_sum = $signed({2'b00, sel_cyl}) - $signed({2'b00, da_reg[15:7]});
        end
        if (seek_sum < 0)
        begin
            seek_cyl = '0;
        end
        else if (seek_sum > CYL_MAX)
        begin
            seek_cyl = CYL_MAX[CYL_W-1:0];
        end
        else
        begin
            seek_cyl = seek_sum[CYL_W-1:0];
        end
    end

    // Next sector after a header read; an out-of-range sector counts as zero.
    assign sec_base = ({1'b0, sel_sec} >= SPT) ? '0 : sel_sec;
    assign sec_inc  = {1'b0, sec_base} + 1'b1;
    assign sec_step = (sec_inc == SPT) ? '0 : sec_inc[SEC_W-1:0];

    // Register access and command execution for one item.
    always_comb
    begin
        csr_next  = csr_reg;
        ba_next   = ba_reg;
        da_next   = da_reg;
        ae_next   = ae_reg;
        ptr_next  = ptr_reg;
        cyl_next  = cyl_reg;
        head_next = head_reg;
        sec_next  = sec_reg;
        csr_work  = csr_wr;
        fifo_fill = 1'b0;
        fifo_w0   = hdr_word;
        fifo_w2   = 16'h0000;
        rv        = 16'h0000;
        irq       = 1'b0;
        if (exec)
        begin
            if (item.operation == OP_READ)
            begin
                case (item.reg_index)
                    REG_CSR: rv = csr_reg | CSR_DRDY;
                    REG_BA:  rv = ba_reg;
                    REG_DA:  rv = da_reg;
                    REG_MP:
                    begin
                        rv       = fifo_reg[ptr_reg];
                        ptr_next = ptr_reg + 1'b1;
                    end
                    REG_AE:  rv = {10'h000, ae_reg};
                    default: rv = 16'h0000;
                endcase
            end
            else
            begin
                case (item.reg_index)
                    REG_CSR:
                    begin
                        ae_next = {ae_reg[5:2], item.write_value[5:4]};
                        if (!csr_wr[7])
                        begin
                            csr_work = csr_wr & ~CSR_ERRS;
                            case (fn)
                                FN_GET_STATUS:
                                begin
                                    if (!da_reg[1] || !present)
                                    begin
                                        csr_work = csr_work | CSR_ERR | ERR_OPI;
                                    end
                                    else
                                    begin
                                        fifo_fill = 1'b1;
                                        fifo_w0   = STAT_BASE | {9'h000, sel_head, 6'h00};
                                    end
                                end
                                FN_SEEK:
                                begin
                                    if (!present)
                                    begin
                                        csr_work = csr_work | CSR_ERR | ERR_OPI;
                                    end
                                    else
                                    begin
                                        for (int u = 0; u < UNITS; u++)
                                        begin
                                            if (32'(unit) == u)
                                            begin
                                                cyl_next[u]  = seek_cyl;
                                                head_next[u] = da_reg[4];
                                            end
                                        end
                                    end
                                end
                                FN_READ_HEADER:
                                begin
                                    if (!present)
                                    begin
                                        csr_work = csr_work | CSR_ERR | ERR_OPI;
                                    end
                                    else
                                    begin
                                        fifo_fill = 1'b1;
                                        fifo_w0   = hdr_word;
                                        fifo_w2   = hdr_crc;
                                        for (int u = 0; u < UNITS; u++)
                                        begin
                                            if (32'(unit) == u)
                                            begin
                                                sec_next[u] = sec_step;
                                            end
                                        end
                                    end
                                end
                                default:
                                begin
                                    csr_work = csr_work;
                                end
                            endcase
                            // Every command completes at once.
                            ptr_next = '0;
                            csr_work = csr_work | CSR_CRDY;
                            irq      = csr_work[6];
                        end
                        csr_next = csr_work;
                    end
                    REG_BA: ba_next = item.write_value;
                    REG_DA: da_next = item.write_value;
                    REG_AE:
                    begin
                        ae_next       = item.write_value[5:0];
                        csr_next[5:4] = item.write_value[1:0];
                    end
                    default:
                    begin
                        csr_next = csr_reg;
                    end
                endcase
            end
        end
    end

    // Control and position registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csr_reg <= CSR_RESET;
            ba_reg  <= '0;
            da_reg  <= '0;
            ae_reg  <= '0;
            ptr_reg <= '0;
            for (int u = 0; u < UNITS; u++)
            begin
                cyl_reg[u]  <= '0;
                head_reg[u] <= 1'b0;
                sec_reg[u]  <= '0;
            end
        end
        else
        begin
            csr_reg  <= csr_next;
            ba_reg   <= ba_next;
            da_reg   <= da_next;
            ae_reg   <= ae_next;
            ptr_reg  <= ptr_next;
            cyl_reg  <= cyl_next;
            head_reg <= head_next;
            sec_reg  <= sec_next;
        end
    end

    // Status FIFO, loaded whole by get-status and read-header.
    always_ff @(posedge clk)
    begin
        if (fifo_fill)
        begin
            for (int i = 0; i < FIFO_DEPTH; i++)
            begin
                if (i == 0)
                begin
                    fifo_reg[i] <= fifo_w0;
                end
                else if (i == 2)
                begin
                    fifo_reg[i] <= fifo_w2;
                end
                else
                begin
                    fifo_reg[i] <= 16'h0000;
                end
            end
        end
    end

    assign result.read_value      = rv;
    assign result.interrupt_pulse = irq;

endmodule

@@ hw/rtl/disk_controller_register_block_top.sv @@
// Top level of the disk controller register block: input and result registers.
//
// Usage:
// The req channel carries one bus access per item: an operation (read or
// write), a register index and a write data word. The rsp channel returns
// one item per access: the register contents for a read (zero for a write)
// and an interrupt pulse when a command completed with interrupt enable set.
// Both channels use valid/ready handshakes.
// Throughput is one item per cycle while rsp is not stalled: the access is
// held in an input register, executed by the register file logic once the
// result register can take it, and captured in the result register.
// Commands (seek, get-status, read-header) finish in the same cycle as the
// access executes.
// When rsp is stalled the result register holds its item and one more
// item waits in the input register; req_ready drops only then.
// Reset clears both pipeline stages, sets drive ready and controller ready
// in the CSR and zeroes all address and unit position registers. The status
// FIFO is not cleared and must be loaded by a command before it is read.
module disk_controller_register_block_top import dcr_pkg::*;
#(
    parameter int UNITS             = UNITS_DEF,
    parameter int SECTORS_PER_TRACK = SECTORS_PER_TRACK_DEF,
    parameter int CYLINDERS         = CYLINDERS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dcr_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output dcr_out_t rsp
);

    logic     stage_valid_reg, stage_valid_next;
    dcr_in_t  stage_reg;
    logic     rsp_valid_reg, rsp_valid_next;
    dcr_out_t rsp_reg;
    dcr_out_t exec_result;
    logic     advance;
    logic     fire;

    // Pipeline flow control.
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = !stage_valid_reg || advance;
    assign fire      = stage_valid_reg && advance;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (req_ready)
        begin
            stage_valid_next = req_valid;
        end
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            stage_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= exec_result;
        end
    end

    dcr_regs #(
        .UNITS             (UNITS),
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
        .CYLINDERS         (CYLINDERS)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (fire),
        .item   (stage_reg),
        .result (exec_result)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hw/rtl/dcr_checker.sv @@
// Port-level assertions for the disk controller register block, bound to the top.
module dcr_checker import dcr_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input dcr_out_t rsp
);

    // A stalled result item holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp item changed while stalled");

    // Every accepted item shows up as a valid result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 rsp_valid)
        else $error("result missing two cycles after acceptance");

    // The input side stalls only while the result side is stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("req_ready low without rsp stall");

    // Interrupts come only from writes, whose read value is zero.
    a_irq_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.interrupt_pulse |-> rsp.read_value == 16'h0000)
        else $error("interrupt with nonzero read value");

endmodule

bind disk_controller_register_block_top dcr_checker u_dcr_checker (.*);
